/* hw/rtl/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared widths, codes and reset values of the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    // Field widths
    localparam int unsigned LEN_W     = 17;
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned STAT_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Block geometry
    localparam int unsigned BLOCK_ALIGN = 16;
    localparam int unsigned HDR_BYTES   = 12;
    localparam int unsigned BKT_MAX     = 7;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OOM     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_HDR = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_RECY = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_0  = 3'd1;

    // Register reset values
    localparam logic [LEN_W-1:0] HEAP_SIZE_RESET = 17'd65536;
    localparam logic [LEN_W-1:0] BUCKET_RESET [BKT_MAX] = '{
        17'd16, 17'd32, 17'd64, 17'd128, 17'd256, 17'd1024, 17'd4096
    };

endpackage

/* hw/rtl/sfla_req_if.sv */
// ----------------------------------------------------------------------------
// sfla_req_if
// Request channel: valid/ready handshake carrying one allocator request item.
// ----------------------------------------------------------------------------
interface sfla_req_if;
    import sfla_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
    logic              null_pointer;

    modport source (
        output valid, opcode, request_size, block_address, null_pointer,
        input  ready
    );

    modport sink (
        input  valid, opcode, request_size, block_address, null_pointer,
        output ready
    );

endinterface

/* hw/rtl/sfla_rsp_if.sv */
// ----------------------------------------------------------------------------
// sfla_rsp_if
// Result channel: valid/ready handshake carrying one allocator result item.
// ----------------------------------------------------------------------------
interface sfla_rsp_if;
    import sfla_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data_address;
    logic [LEN_W-1:0]  block_size;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, data_address, block_size, status,
        input  ready
    );

    modport sink (
        input  valid, data_address, block_size, status,
        output ready
    );

endinterface

/* hw/rtl/sfla_hdr_store.sv */
// ----------------------------------------------------------------------------
// sfla_hdr_store
// Block header memory: one read and one write port, registered read data,
// and a clearing sweep after reset that zeroes every entry.
// ----------------------------------------------------------------------------
module sfla_hdr_store #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned DATA_W = 31
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic                     busy
);
    import sfla_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_reg;
    logic              clr_next;
    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // Clearing sweep: one entry per cycle from reset
    always_comb
    begin
        clr_next = clr_reg;
        cnt_next = cnt_reg;
        if (clr_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write port shared between the sweep and the datapath
    assign mem_we = clr_reg || wr_en;
    assign mem_wa = clr_reg ? cnt_reg : wr_addr;
    assign mem_wd = clr_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_reg;

`ifndef SYNTH
    // The datapath never writes while the sweep owns the port
    a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !wr_en)
        else $error("header write during clearing sweep");

    // Sweep ends only after the last entry
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_reg) |-> $past(cnt_reg) == LAST)
        else $error("clearing sweep ended early");

    // Sweep runs once per reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_reg |=> !clr_reg)
        else $error("clearing sweep restarted");
`endif

endmodule

/* hw/rtl/segregated_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Heap allocator with per-size LIFO free lists and a bump pointer.
// ----------------------------------------------------------------------------
// Each request item passes a decode step, which reads the block header
// memory, and then an execute step, which checks the header, updates the
// list head or bump pointer and writes the header back; the registered read
// of the header memory sets this split. A result waits in an output
// register, so the next request is taken while it is still unread. After
// reset the header memory is swept clear, one entry a cycle, through all
// min(HEAP_BYTES, 65536)/16 entries (4096 by default); no request is taken
// during the sweep, while register writes are taken at any time. Registers
// are to be written only while no request is in flight.
module segregated_free_list_allocator #(
    parameter int unsigned HEAP_BYTES  = 65536,
    parameter int unsigned NUM_BUCKETS = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfla_pkg::LEN_W-1:0]       cfg_data,
    sfla_req_if.sink                         request,
    sfla_rsp_if.source                       result
);
    import sfla_pkg::*;

    localparam int unsigned HDR_DEPTH =
        ((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536) / BLOCK_ALIGN;
    localparam int unsigned IDX_W   = $clog2(HDR_DEPTH);
    localparam int unsigned LINK_W  = IDX_W + 1;
    localparam int unsigned ENTRY_W = 1 + LEN_W + LINK_W;
    localparam int unsigned BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned LIM_CAP = (HEAP_BYTES > 131071) ? 131071 : HEAP_BYTES;
    localparam int unsigned HIX_W   = LEN_W - 4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Configuration
    logic [LEN_W-1:0]  heap_size_reg;
    logic [LEN_W-1:0]  bucket_size_reg [BKT_MAX];

    // Allocator state
    state_t            state_reg;
    state_t            state_next;
    logic [LEN_W-1:0]  bump_reg;
    logic [LEN_W-1:0]  bump_next;
    logic [LINK_W-1:0] head_reg  [NUM_BUCKETS];
    logic [LINK_W-1:0] head_next [NUM_BUCKETS];

    // Decoded request
    logic [OP_W-1:0]   op_reg;
    logic              fix_reg;
    logic [STAT_W-1:0] fix_st_reg;
    logic              pop_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LEN_W-1:0]  size_reg;
    logic [IDX_W-1:0]  hidx_reg;
    logic              fix_n;
    logic [STAT_W-1:0] fix_st_n;
    logic              pop_n;
    logic [LEN_W-1:0]  size_n;
    logic [IDX_W-1:0]  rd_addr;

    // Output register
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [ADDR_W-1:0] rsp_addr_reg;
    logic [LEN_W-1:0]  rsp_size_reg;
    logic [STAT_W-1:0] rsp_st_reg;

    // Datapath
    logic                   acc;
    logic                   go;
    logic                   clr_busy;
    logic [NUM_BUCKETS-1:0] bkt_en;
    logic                   a_hit;
    logic [BKT_W-1:0]       a_idx;
    logic                   f_hit;
    logic [BKT_W-1:0]       f_idx;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   rd_marked;
    logic [LEN_W-1:0]       rd_length;
    logic [LINK_W-1:0]      rd_link;
    logic                   hdr_we;
    logic [IDX_W-1:0]       hdr_wa;
    logic [ENTRY_W-1:0]     hdr_wd;
    logic [LEN_W-1:0]       limit;
    logic [LEN_W:0]         round_sum;
    logic [LEN_W:0]         total;
    logic [LEN_W+1:0]       bump_end;
    logic                   bump_in_range;
    logic [ADDR_W-1:0]      res_addr;
    logic [LEN_W-1:0]       res_size;
    logic [STAT_W-1:0]      res_st;

    // Handshakes
    assign request.ready = (state_reg == ST_IDLE) && !clr_busy;
    assign acc = request.valid && request.ready;
    assign go  = (state_reg == ST_EXEC) && (!rsp_valid_reg || result.ready);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= HEAP_SIZE_RESET;
            for (int i = 0; i < BKT_MAX; i++)
            begin
                bucket_size_reg[i] <= BUCKET_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_HEAP_SIZE)
            begin
                heap_size_reg <= cfg_data;
            end
            for (int i = 0; i < BKT_MAX; i++)
            begin
                if (cfg_index == CFG_IDX_W'(CFG_BUCKET_0 + i))
                begin
                    bucket_size_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Bucket table ends at the first zero size
    always_comb
    begin
        logic run;
        run    = 1'b1;
        bkt_en = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            run       = run && (bucket_size_reg[i] != '0);
            bkt_en[i] = run;
        end
    end

    // First bucket that holds the requested size
    always_comb
    begin
        a_hit = 1'b0;
        a_idx = '0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (bkt_en[i] && (request.request_size <= bucket_size_reg[i]))
            begin
                a_hit = 1'b1;
                a_idx = BKT_W'(i);
            end
        end
    end

    // First bucket whose size equals the stored length
    always_comb
    begin
        f_hit = 1'b0;
        f_idx = '0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (bkt_en[i] && (rd_length == bucket_size_reg[i]))
            begin
                f_hit = 1'b1;
                f_idx = BKT_W'(i);
            end
        end
    end

    // Request decode and header read address
    always_comb
    begin
        logic [LINK_W-1:0] a_head;
        a_head   = head_reg[a_idx];
        fix_n    = 1'b0;
        fix_st_n = ST_OK;
        pop_n    = 1'b0;
        size_n   = request.request_size;
        unique case (request.opcode)
            OP_ALLOC:
            begin
                if (request.request_size == '0)
                begin
                    fix_n    = 1'b1;
                    fix_st_n = ST_NULL;
                end
                else
                begin
                    pop_n = a_hit && (a_head != '0);
                    if (a_hit)
                    begin
                        size_n = bucket_size_reg[a_idx];
                    end
                end
            end
            OP_FREE, OP_QUERY:
            begin
                if (request.null_pointer)
                begin
                    fix_n    = 1'b1;
                    fix_st_n = ST_NULL;
                end
                else if ((request.block_address[3:0] != 4'hC) ||
                         ({1'b0, request.block_address[ADDR_W-1:4]} >=
                          HIX_W'(HDR_DEPTH)))
                begin
                    fix_n    = 1'b1;
                    fix_st_n = ST_BAD_HDR;
                end
            end
            default:
            begin
                fix_n    = 1'b1;
                fix_st_n = ST_OK;
            end
        endcase
        rd_addr = pop_n ? IDX_W'(a_head - 1'b1) : request.block_address[IDX_W+3:4];
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg     <= request.opcode;
            fix_reg    <= fix_n;
            fix_st_reg <= fix_st_n;
            pop_reg    <= pop_n;
            bkt_reg    <= a_idx;
            size_reg   <= size_n;
            hidx_reg   <= rd_addr;
        end
    end

    // Header memory
    sfla_hdr_store #(
        .DEPTH  (HDR_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_hdr_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (hdr_we),
        .wr_addr (hdr_wa),
        .wr_data (hdr_wd),
        .busy    (clr_busy)
    );

    assign rd_marked = rd_data[ENTRY_W-1];
    assign rd_length = rd_data[LINK_W +: LEN_W];
    assign rd_link   = rd_data[LINK_W-1:0];

    // Bump arithmetic: header plus size rounded to the block alignment
    assign limit = (heap_size_reg < LEN_W'(LIM_CAP)) ? heap_size_reg : LEN_W'(LIM_CAP);
    assign round_sum = {1'b0, size_reg} + (LEN_W+1)'(HDR_BYTES + BLOCK_ALIGN - 1);
    assign total     = {round_sum[LEN_W:4], 4'b0000};
    assign bump_end  = {2'b00, bump_reg} + {1'b0, total};
    assign bump_in_range = bump_reg[LEN_W-1:4] < HIX_W'(HDR_DEPTH);

    // Execute: header check, list update, bump, header write-back
    always_comb
    begin
        res_addr  = '0;
        res_size  = '0;
        res_st    = ST_OK;
        hdr_we    = 1'b0;
        hdr_wa    = hidx_reg;
        hdr_wd    = rd_data;
        bump_next = bump_reg;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            head_next[i] = head_reg[i];
        end
        if (fix_reg)
        begin
            res_st = fix_st_reg;
        end
        else
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (pop_reg)
                    begin
                        res_addr           = ADDR_W'({hidx_reg, 4'hC});
                        res_size           = rd_length;
                        head_next[bkt_reg] = rd_link;
                    end
                    else if (bump_end > {2'b00, limit})
                    begin
                        res_st = ST_OOM;
                    end
                    else
                    begin
                        hdr_we    = bump_in_range;
                        hdr_wa    = bump_reg[IDX_W+3:4];
                        hdr_wd    = {1'b1, size_reg, LINK_W'(0)};
                        bump_next = bump_end[LEN_W-1:0];
                        res_addr  = {bump_reg[ADDR_W-1:4], 4'hC};
                        res_size  = size_reg;
                    end
                end
                OP_FREE:
                begin
                    if (!rd_marked)
                    begin
                        res_st = ST_BAD_HDR;
                    end
                    else if (f_hit)
                    begin
                        hdr_we           = 1'b1;
                        hdr_wd           = {1'b1, rd_length, head_reg[f_idx]};
                        head_next[f_idx] = LINK_W'(hidx_reg) + 1'b1;
                    end
                    else
                    begin
                        res_st = ST_NO_RECY;
                    end
                end
                OP_QUERY:
                begin
                    if (!rd_marked)
                    begin
                        res_st = ST_BAD_HDR;
                    end
                    else
                    begin
                        res_size = rd_length;
                    end
                end
                default:
                begin
                    res_st = ST_OK;
                end
            endcase
        end
        hdr_we = hdr_we && go;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = go ? 1'b1 : (rsp_valid_reg && !result.ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bump_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (go)
            begin
                bump_reg <= bump_next;
                for (int i = 0; i < NUM_BUCKETS; i++)
                begin
                    head_reg[i] <= head_next[i];
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rsp_addr_reg <= res_addr;
            rsp_size_reg <= res_size;
            rsp_st_reg   <= res_st;
        end
    end

    assign result.valid        = rsp_valid_reg;
    assign result.data_address = rsp_addr_reg;
    assign result.block_size   = rsp_size_reg;
    assign result.status       = rsp_st_reg;

`ifndef SYNTH
    // Nothing in flight while the header memory is being cleared
    a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> (state_reg == ST_IDLE) && !rsp_valid_reg)
        else $error("activity during header clearing sweep");

    // An accepted item always moves to execute
    a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> state_reg == ST_EXEC)
        else $error("accepted item not executed");

    // Bump pointer stays block aligned
    a_bump_align: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg[3:0] == 4'd0)
        else $error("bump pointer misaligned");

    // Header writes only for decoded, non-trivial items
    a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_we |-> (state_reg == ST_EXEC) && !fix_reg && (op_reg != OP_QUERY))
        else $error("unexpected header write");

    // A stalled execute keeps its decoded item
    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && !go |=> (state_reg == ST_EXEC) && $stable(op_reg)
            && $stable(hidx_reg) && $stable(size_reg))
        else $error("stalled item changed");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the segregated free-list allocator. A set of directed requests
// covers null sizes, bucket rounding, list pops, double free, bad headers,
// unbucketed frees and out-of-memory; a long result stall fills the block up;
// random traffic of allocate/free/query sequences then runs under three
// register settings and three idle patterns. Every result is checked against
// a behavioral copy of the heap state kept here.
// ----------------------------------------------------------------------------
module tb;
    import sfla_pkg::*;

    localparam int unsigned    HEAP_LIMIT  = 65536;
    localparam int unsigned    HDR_ENTRIES = HEAP_LIMIT / BLOCK_ALIGN;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] data_address;
        logic [LEN_W-1:0]  block_size;
        logic [STAT_W-1:0] status;
    } alloc_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    sfla_req_if request_ch ();
    sfla_rsp_if result_ch ();

    segregated_free_list_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    // Register copies
    logic [LEN_W-1:0] heap_reg;
    logic [LEN_W-1:0] bucket_reg [BKT_MAX];

    // Heap state copy
    int unsigned      bump_ptr;
    logic [12:0]      list_head [BKT_MAX];
    bit               hdr_used  [HDR_ENTRIES];
    logic [LEN_W-1:0] hdr_len   [HDR_ENTRIES];
    logic [12:0]      hdr_next  [HDR_ENTRIES];

    // Expected replies and bookkeeping
    alloc_reply_t      pending_replies[$];
    alloc_reply_t      last_reply;
    logic [ADDR_W-1:0] live_blocks[$];
    int                src_idle_pct;
    int                snk_idle_pct;
    int                out_hold;
    int                mismatch_count;
    int                replies_seen;
    int                op_count [4];
    int                status_count [8];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Expected reply for one accepted request; updates the heap copy
    function automatic alloc_reply_t model_request(
        input logic [OP_W-1:0]   op,
        input logic [LEN_W-1:0]  size,
        input logic [ADDR_W-1:0] addr,
        input logic              nul
    );
        alloc_reply_t r;
        int           pick;
        int           k;
        bit           done;
        int unsigned  grant;
        int unsigned  span;
        int unsigned  lim;
        int unsigned  off;
        int unsigned  hdr;
        r = '0;
        if (op == OP_ALLOC)
        begin
            if (size == 0)
                r.status = ST_NULL;
            else
            begin
                // first bucket that fits; the table stops at a zero entry
                grant = 32'(size);
                pick  = -1;
                k     = 0;
                while (pick < 0 && k < BKT_MAX && bucket_reg[k] != 0)
                begin
                    if (size <= bucket_reg[k])
                    begin
                        pick  = k;
                        grant = 32'(bucket_reg[k]);
                    end
                    k++;
                end
                if (pick >= 0 && list_head[pick] != 0)
                begin
                    hdr             = 32'(list_head[pick]) - 1;
                    list_head[pick] = hdr_next[hdr];
                    r.data_address  = ADDR_W'(hdr * BLOCK_ALIGN + HDR_BYTES);
                    r.block_size    = hdr_len[hdr];
                end
                else
                begin
                    lim  = (32'(heap_reg) < HEAP_LIMIT) ? 32'(heap_reg) : HEAP_LIMIT;
                    span = (HDR_BYTES + grant + 15) & 32'hFFFF_FFF0;
                    if (bump_ptr + span > lim)
                        r.status = ST_OOM;
                    else
                    begin
                        hdr            = bump_ptr >> 4;
                        hdr_used[hdr]  = 1'b1;
                        hdr_len[hdr]   = LEN_W'(grant);
                        bump_ptr       = bump_ptr + span;
                        r.data_address = ADDR_W'(hdr * BLOCK_ALIGN + HDR_BYTES);
                        r.block_size   = LEN_W'(grant);
                    end
                end
            end
        end
        else if (op == OP_FREE || op == OP_QUERY)
        begin
            if (nul)
                r.status = ST_NULL;
            else if (32'(addr) < HDR_BYTES)
                r.status = ST_BAD_HDR;
            else
            begin
                off = 32'(addr) - HDR_BYTES;
                hdr = off >> 4;
                if ((off & 15) != 0 || !hdr_used[hdr])
                    r.status = ST_BAD_HDR;
                else if (op == OP_QUERY)
                    r.block_size = hdr_len[hdr];
                else
                begin
                    // push onto the list whose size matches the stored length
                    done = 1'b0;
                    k    = 0;
                    while (!done && k < BKT_MAX && bucket_reg[k] != 0)
                    begin
                        if (hdr_len[hdr] == bucket_reg[k])
                        begin
                            hdr_next[hdr] = list_head[k];
                            list_head[k]  = 13'(hdr + 1);
                            done          = 1'b1;
                        end
                        k++;
                    end
                    if (!done)
                        r.status = ST_NO_RECY;
                end
            end
        end
        return r;
    endfunction

    // Offer one request item; returns once it is accepted
    task automatic send_request(
        input logic [OP_W-1:0]   op,
        input logic [LEN_W-1:0]  size,
        input logic [ADDR_W-1:0] addr,
        input logic              nul
    );
        @(negedge clk);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        request_ch.valid         <= 1'b1;
        request_ch.opcode        <= op;
        request_ch.request_size  <= size;
        request_ch.block_address <= addr;
        request_ch.null_pointer  <= nul;
        do
            @(posedge clk);
        while (!request_ch.ready);
        last_reply = model_request(op, size, addr, nul);
        pending_replies.push_back(last_reply);
        op_count[op]++;
        status_count[last_reply.status]++;
        if (op == OP_ALLOC && last_reply.status == ST_OK)
            live_blocks.push_back(last_reply.data_address);
    endtask

    // Drop valid and wait until every reply has come back
    task automatic wait_idle;
        @(negedge clk);
        request_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_HEAP_SIZE)
            heap_reg = val;
        else
            bucket_reg[idx - CFG_BUCKET_0] = val;
    endtask

    // Write the heap limit and the whole bucket table
    task automatic load_config(
        input logic [LEN_W-1:0] heap,
        input logic [LEN_W-1:0] sizes [BKT_MAX]
    );
        write_reg(CFG_HEAP_SIZE, heap);
        for (int i = 0; i < BKT_MAX; i++)
            write_reg(CFG_IDX_W'(CFG_BUCKET_0 + i), sizes[i]);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Reset-value registers: rounding, pops, double free, bad headers
    task automatic test_basic_requests;
        logic [ADDR_W-1:0] exact_blk;
        send_request(OP_ALLOC, 17'd0, 16'd0, 1'b0);         // zero size
        send_request(OP_ALLOC, 17'd1, 16'd0, 1'b1);         // null bit ignored
        send_request(OP_ALLOC, 17'd16, 16'hFFFF, 1'b0);     // exact bucket fit
        send_request(OP_ALLOC, 17'd4096, 16'd0, 1'b0);      // largest bucket
        send_request(OP_ALLOC, 17'd4097, 16'd0, 1'b0);      // above all buckets
        exact_blk = last_reply.data_address;
        send_request(OP_ALLOC, 17'h10000, 16'd0, 1'b0);     // out of memory
        send_request(OP_QUERY, 17'd0, 16'd12, 1'b0);
        send_request(OP_FREE, 17'h1FFFF, 16'd12, 1'b0);
        send_request(OP_FREE, 17'd0, 16'd12, 1'b0);         // double free
        send_request(OP_ALLOC, 17'd10, 16'd0, 1'b0);        // pops the freed block
        send_request(OP_QUERY, 17'd0, exact_blk, 1'b0);
        send_request(OP_FREE, 17'd0, exact_blk, 1'b0);      // length in no bucket
        send_request(OP_FREE, 17'd0, 16'd12, 1'b1);         // null pointer
        send_request(OP_QUERY, 17'd0, 16'd12, 1'b1);
        send_request(OP_QUERY, 17'd0, 16'd0, 1'b0);         // below the header
        send_request(OP_FREE, 17'd0, 16'd13, 1'b0);         // misaligned
        send_request(OP_QUERY, 17'd0, 16'hFFFC, 1'b0);      // unmarked header
        send_request(OP_FREE, 17'd0, 16'hFFFF, 1'b0);
        send_request(OP_UNUSED, 17'h1FFFF, 16'hFFFF, 1'b1); // unused opcode
        wait_idle();
    endtask

    // Result side held off for a long stretch while requests keep coming
    task automatic test_result_backpressure;
        src_idle_pct = 0;
        out_hold     = 80;
        repeat (12)
            send_request(OP_QUERY, 17'd0, 16'd12, 1'b0);
        wait_idle();
    endtask

    // Tiny heap with an empty table, then one bucket at the largest size
    task automatic test_config_extremes;
        load_config(17'd16, '{17'd0, 17'd32, 17'd64, 17'd128, 17'd256, 17'd1024, 17'd4096});
        send_request(OP_ALLOC, 17'd4, 16'd0, 1'b0);
        send_request(OP_FREE, 17'd0, 16'd12, 1'b0);
        send_request(OP_QUERY, 17'd0, 16'd12, 1'b0);
        wait_idle();
        load_config(17'd65536, '{17'd65536, 17'd0, 17'd48, 17'd0, 17'd0, 17'd0, 17'd0});
        send_request(OP_ALLOC, 17'd1, 16'd0, 1'b0);
        send_request(OP_ALLOC, 17'd65536, 16'd0, 1'b0);
        send_request(OP_FREE, 17'd0, 16'd12, 1'b0);
        wait_idle();
    endtask

    // Mostly well-formed alloc/free/query traffic plus raw noise
    task automatic test_random_traffic(
        input int               src_pct,
        input int               snk_pct,
        input logic [LEN_W-1:0] heap,
        input logic [LEN_W-1:0] sizes [BKT_MAX],
        input int               items
    );
        int unsigned       roll;
        int unsigned       pos;
        logic [LEN_W-1:0]  sz;
        logic [ADDR_W-1:0] blk;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        load_config(heap, sizes);
        repeat (items)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    sz = LEN_W'($urandom_range(1, 300));
                else if (roll < 93)
                    sz = LEN_W'($urandom_range(1, 1100));
                else if (roll < 97)
                    sz = LEN_W'($urandom_range(1, 4200));
                else if (roll < 99)
                    sz = LEN_W'($urandom_range(0, 17'h1FFFF));
                else
                    sz = '0;
                send_request(OP_ALLOC, sz, 16'($urandom), 1'($urandom_range(1)));
            end
            else if (roll < 87 && live_blocks.size() != 0)
            begin
                pos = $urandom_range(live_blocks.size() - 1);
                blk = live_blocks[pos];
                if (roll < 75)
                begin
                    // an occasional freed block stays listed to get double frees
                    if ($urandom_range(9) != 0)
                        live_blocks.delete(pos);
                    send_request(OP_FREE, 17'($urandom), blk, $urandom_range(19) == 0);
                end
                else
                    send_request(OP_QUERY, 17'($urandom), blk, $urandom_range(19) == 0);
            end
            else
                send_request(2'($urandom_range(3)), 17'($urandom), 16'($urandom),
                             1'($urandom_range(1)));
        end
        wait_idle();
    endtask

    // Result ready, with a countable hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                out_hold--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Reply checker
    initial
    begin
        alloc_reply_t got;
        alloc_reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.data_address = result_ch.data_address;
                got.block_size   = result_ch.block_size;
                got.status       = result_ch.status;
                replies_seen++;
                if (pending_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected reply: addr %h size %0d status %0d",
                                 $realtime, got.data_address, got.block_size, got.status);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] reply mismatch: addr exp %h got %h, ",
                                      "size exp %0d got %0d, status exp %0d got %0d"},
                                     $realtime, want.data_address, got.data_address,
                                     want.block_size, got.block_size, want.status, got.status);
                    end
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n                    = 1'b0;
        cfg_write                = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        request_ch.valid         = 1'b0;
        request_ch.opcode        = OP_ALLOC;
        request_ch.request_size  = '0;
        request_ch.block_address = '0;
        request_ch.null_pointer  = 1'b0;
        heap_reg                 = HEAP_SIZE_RESET;
        bucket_reg               = BUCKET_RESET;
        bump_ptr                 = 0;
        src_idle_pct             = 16;
        snk_idle_pct             = 85;
        out_hold                 = 0;
        mismatch_count           = 0;
        replies_seen             = 0;
        for (int i = 0; i < BKT_MAX; i++)
            list_head[i] = '0;
        for (int i = 0; i < HDR_ENTRIES; i++)
            hdr_used[i] = 1'b0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        for (int i = 0; i < 8; i++)
            status_count[i] = 0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_requests();
        test_result_backpressure();
        test_config_extremes();
        test_random_traffic(16, 85, 17'd65536,
            '{17'd16, 17'd32, 17'd64, 17'd128, 17'd256, 17'd1024, 17'd4096}, 205);
        test_random_traffic(85, 16, 17'd50000,
            '{17'd24, 17'd48, 17'd96, 17'd0, 17'd512, 17'd2048, 17'd8192}, 205);
        test_random_traffic(0, 0, 17'd65536,
            '{17'd1, 17'd8, 17'd40, 17'd200, 17'd700, 17'd3000, 17'd65536}, 205);

        // allow a stray reply to show up
        repeat (20)
            @(posedge clk);

        $display("Covered %0d requests: %0d allocate, %0d free, %0d query, %0d unused opcode",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_QUERY],
                 op_count[OP_UNUSED]);
        $display({"Replies %0d: %0d ok, %0d null, %0d out of memory, %0d bad header, ",
                  "%0d not recycled; %0d mismatches"},
                 replies_seen, status_count[ST_OK], status_count[ST_NULL],
                 status_count[ST_OOM], status_count[ST_BAD_HDR], status_count[ST_NO_RECY],
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sfla_pkg.sv
hw/rtl/sfla_req_if.sv
hw/rtl/sfla_rsp_if.sv
hw/rtl/sfla_hdr_store.sv
hw/rtl/segregated_free_list_allocator.sv
test/tb.sv
